>>> rtl/ntc_beta_temperature_convert_defines.svh
// ----------------------------------------------------------------------------
// NTC beta converter assertion macros
// Shared concurrent assertion forms used by the converter's checker.
// ----------------------------------------------------------------------------
`ifndef NTC_BETA_TEMPERATURE_CONVERT_DEFINES_SVH
`define NTC_BETA_TEMPERATURE_CONVERT_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define NTCB_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define NTCB_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> rtl/ntcb_pkg.sv
// ----------------------------------------------------------------------------
// NTC beta converter package
// Widths, constants, register indexes and shared types of the converter.
// ----------------------------------------------------------------------------
package ntcb_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 23;
    localparam int FS_W         = 16;
    localparam int RES_W        = 23;
    localparam int BETA_W       = 16;
    localparam int TNOM_W       = 16;
    localparam int TEMP_W       = 18;
    localparam int STATUS_W     = 2;

    localparam int RATIO_W      = 16;
    localparam int RATIO_STAGES = RATIO_W;
    localparam int PROD_W       = 40;
    localparam int LOG_FRAC     = 16;
    localparam int LOG_INT_W    = 6;
    localparam int LOG_W        = LOG_INT_W + LOG_FRAC;
    localparam int MANT_W       = 31;
    localparam int LN_W         = 22;
    localparam int DIV_W        = 40;

    localparam logic [RATIO_W-1:0] RATIO_LO     = 16'd7;
    localparam logic [RATIO_W-1:0] RATIO_HI     = 16'd65529;
    localparam logic [31:0]        LN2_Q32      = 32'd2977044472;
    localparam logic [DIV_W-1:0]   HUNDRED_Q32  = 40'd429496729600;
    localparam logic [DIV_W-1:0]   TQ_MAX       = 40'd127315;
    localparam logic signed [TEMP_W-1:0] KELVIN_CENTI = 18'sd27315;
    localparam logic signed [TEMP_W-1:0] T_MAX_CENTI  = 18'sd100000;
    localparam logic signed [TEMP_W-1:0] T_MIN_CENTI  = -18'sd27315;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ADC_FULL_SCALE = 3'd0,
        REG_SERIES_RES     = 3'd1,
        REG_NOMINAL_RES    = 3'd2,
        REG_BETA           = 3'd3,
        REG_NOMINAL_TEMP   = 3'd4
    } cfg_reg_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FS_ZERO   = 2'd1,
        STATUS_SATURATED = 2'd2
    } status_t;

    typedef struct packed {
        logic [FS_W-1:0]          adc_full_scale;
        logic [RES_W-1:0]         series_resistance;
        logic [RES_W-1:0]         nominal_resistance;
        logic [BETA_W-1:0]        beta_kelvin;
        logic signed [TNOM_W-1:0] nominal_temp_centi;
    } cfg_t;

endpackage

>>> rtl/ntc_beta_temperature_convert.sv
// ----------------------------------------------------------------------------
// NTC thermistor beta temperature converter
// Raw divider ADC sample in, temperature in hundredths of a degree out.
// ----------------------------------------------------------------------------
// Accepts one sample in every clock cycle (busy is always low) and returns
// each result, marked by a one-cycle done strobe, in input order; results
// cannot be held off. The pipeline holds 18 stages for the ratio and the
// resistance products, 17 for the two logarithms, 2 for the natural log
// scaling, 40 for the division by beta, 1 for the reciprocal sum, 40 for the
// final reciprocal and 1 output stage. The user must write the registers
// through cfg_we, cfg_index and cfg_data only while no sample is in flight;
// the block itself does not enforce this.
module ntc_beta_temperature_convert
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic [ntcb_pkg::SAMPLE_W-1:0]          sample,
    output logic                                   done,
    output logic signed [ntcb_pkg::TEMP_W-1:0]     temperature_centi,
    output logic [ntcb_pkg::STATUS_W-1:0]          status,
    input  logic                                   cfg_we,
    input  logic [ntcb_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ntcb_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import ntcb_pkg::*;

    cfg_t                 cfg_reg;

    logic                 ratio_valid;
    logic [PROD_W-1:0]    num;
    logic [PROD_W-1:0]    den;
    logic                 lg_num_valid;
    logic                 lg_den_valid;
    logic [LOG_W-1:0]     lg_num;
    logic [LOG_W-1:0]     lg_den;

    logic signed [LOG_W:0] lg_diff;
    logic [LN_W-1:0]      lg_mag;
    logic                 ln1_valid_reg;
    logic                 ln1_neg_reg;
    logic [LN_W-1:0]      ln1_mag_reg;
    logic [LN_W+31:0]     ln_prod;
    logic [LN_W+32:0]     ln_sum;
    logic                 ln2_valid_reg;
    logic                 ln2_neg_reg;
    logic [LN_W-1:0]      ln2_mag_reg;

    logic signed [TEMP_W-1:0] tk;
    logic                 bad_cfg;
    logic [DIV_W-1:0]     beta_dividend;
    logic [DIV_W-1:0]     beta_divisor;
    logic [DIV_W-1:0]     tnom_dividend;
    logic [DIV_W-1:0]     tnom_divisor;
    logic                 q1_valid;
    logic                 c_valid;
    logic [DIV_W-1:0]     q1;
    logic [DIV_W-1:0]     c_q;
    logic [DIV_W-1:0]     neg_line_reg;

    logic signed [DIV_W+1:0] inv_next;
    logic signed [DIV_W+1:0] inv_reg;
    logic                 inv_valid_reg;
    logic [DIV_W-1:0]     recip_dividend;
    logic [DIV_W-1:0]     zero_line_reg;
    logic [DIV_W-1:0]     negi_line_reg;
    logic                 tq_valid;
    logic [DIV_W-1:0]     tq;

    logic                 done_reg;
    logic signed [TEMP_W-1:0] temp_reg;
    logic signed [TEMP_W-1:0] temp_next;
    status_t              status_reg;
    status_t              status_next;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.adc_full_scale     <= 16'd4095;
            cfg_reg.series_resistance  <= 23'd10000;
            cfg_reg.nominal_resistance <= 23'd10000;
            cfg_reg.beta_kelvin        <= 16'd3950;
            cfg_reg.nominal_temp_centi <= 16'sd2500;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ADC_FULL_SCALE: cfg_reg.adc_full_scale     <= cfg_data[FS_W-1:0];
                REG_SERIES_RES:     cfg_reg.series_resistance  <= cfg_data[RES_W-1:0];
                REG_NOMINAL_RES:    cfg_reg.nominal_resistance <= cfg_data[RES_W-1:0];
                REG_BETA:           cfg_reg.beta_kelvin        <= cfg_data[BETA_W-1:0];
                REG_NOMINAL_TEMP:   cfg_reg.nominal_temp_centi <= cfg_data[TNOM_W-1:0];
                default:            ;
            endcase
        end
    end

    ntcb_ratio u_ratio
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .sample    (sample),
        .cfg       (cfg_reg),
        .out_valid (ratio_valid),
        .num       (num),
        .den       (den)
    );

    ntcb_log2 u_log_num
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ratio_valid),
        .x         (num),
        .out_valid (lg_num_valid),
        .lg        (lg_num)
    );

    ntcb_log2 u_log_den
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ratio_valid),
        .x         (den),
        .out_valid (lg_den_valid),
        .lg        (lg_den)
    );

    // ln(R/Rnom) = (log2 num - log2 den) * ln2, rounded half away from zero.
    assign lg_diff = $signed({1'b0, lg_num}) - $signed({1'b0, lg_den});
    assign lg_mag  = lg_diff[LOG_W] ? LN_W'(-lg_diff) : lg_diff[LN_W-1:0];
    assign ln_prod = ln1_mag_reg * LN2_Q32;
    assign ln_sum  = {1'b0, ln_prod} + (LN_W+33)'(64'h80000000);

    always_ff @(posedge clk)
    begin
        ln1_neg_reg <= lg_diff[LOG_W];
        ln1_mag_reg <= lg_mag;
        ln2_neg_reg <= ln1_neg_reg;
        ln2_mag_reg <= ln_sum[LN_W+31:32];
    end

    assign tk = $signed({{(TEMP_W-TNOM_W){cfg_reg.nominal_temp_centi[TNOM_W-1]}},
                         cfg_reg.nominal_temp_centi}) + KELVIN_CENTI;

    assign bad_cfg = (cfg_reg.series_resistance == '0) ||
                     (cfg_reg.nominal_resistance == '0) ||
                     (cfg_reg.beta_kelvin == '0) ||
                     tk[TEMP_W-1] || (tk == '0);

    assign beta_dividend = {2'b00, ln2_mag_reg, 16'h0000} +
                           {{(DIV_W-BETA_W+1){1'b0}}, cfg_reg.beta_kelvin[BETA_W-1:1]};
    assign beta_divisor  = {{(DIV_W-BETA_W){1'b0}}, cfg_reg.beta_kelvin};
    assign tnom_dividend = HUNDRED_Q32 + {{(DIV_W-TEMP_W+2){1'b0}}, tk[TEMP_W-2:1]};
    assign tnom_divisor  = {{(DIV_W-TEMP_W+1){1'b0}}, tk[TEMP_W-2:0]};

    ntcb_div u_div_beta
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ln2_valid_reg),
        .dividend  (beta_dividend),
        .divisor   (beta_divisor),
        .out_valid (q1_valid),
        .quotient  (q1)
    );

    // The nominal reciprocal term runs beside the beta division so both land together.
    ntcb_div u_div_tnom
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (ln2_valid_reg),
        .dividend  (tnom_dividend),
        .divisor   (tnom_divisor),
        .out_valid (c_valid),
        .quotient  (c_q)
    );

    assign inv_next = neg_line_reg[DIV_W-1] ?
                      ($signed({2'b00, c_q}) - $signed({2'b00, q1})) :
                      ($signed({2'b00, c_q}) + $signed({2'b00, q1}));

    assign recip_dividend = HUNDRED_Q32 + {1'b0, inv_reg[DIV_W-1:1]};

    ntcb_div u_div_recip
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (inv_valid_reg),
        .dividend  (recip_dividend),
        .divisor   (inv_reg[DIV_W-1:0]),
        .out_valid (tq_valid),
        .quotient  (tq)
    );

    always_ff @(posedge clk)
    begin
        neg_line_reg  <= {neg_line_reg[DIV_W-2:0], ln2_neg_reg};
        inv_reg       <= inv_next;
        zero_line_reg <= {zero_line_reg[DIV_W-2:0], (inv_reg == '0)};
        negi_line_reg <= {negi_line_reg[DIV_W-2:0], inv_reg[DIV_W+1]};
    end

    always_comb
    begin
        if (cfg_reg.adc_full_scale == '0)
        begin
            temp_next   = '0;
            status_next = STATUS_FS_ZERO;
        end
        else if (bad_cfg || negi_line_reg[DIV_W-1])
        begin
            temp_next   = T_MIN_CENTI;
            status_next = STATUS_SATURATED;
        end
        else if (zero_line_reg[DIV_W-1] || tq > TQ_MAX)
        begin
            temp_next   = T_MAX_CENTI;
            status_next = STATUS_SATURATED;
        end
        else
        begin
            temp_next   = $signed({1'b0, tq[TEMP_W-2:0]}) - KELVIN_CENTI;
            status_next = STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ln1_valid_reg <= 1'b0;
            ln2_valid_reg <= 1'b0;
            inv_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            ln1_valid_reg <= lg_num_valid && lg_den_valid;
            ln2_valid_reg <= ln1_valid_reg;
            inv_valid_reg <= q1_valid && c_valid;
            done_reg      <= tq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        temp_reg   <= temp_next;
        status_reg <= status_next;
    end

    assign done              = done_reg;
    assign temperature_centi = temp_reg;
    assign status            = status_reg;

endmodule

>>> rtl/ntcb_div.sv
// ----------------------------------------------------------------------------
// NTC beta converter divider
// Unsigned restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module ntcb_div
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [ntcb_pkg::DIV_W-1:0] dividend,
    input  logic [ntcb_pkg::DIV_W-1:0] divisor,
    output logic                      out_valid,
    output logic [ntcb_pkg::DIV_W-1:0] quotient
);
    import ntcb_pkg::*;

    logic [DIV_W-1:0] valid_reg;
    logic [DIV_W-1:0] valid_next;
    logic [DIV_W-1:0] rem_reg  [DIV_W];
    logic [DIV_W-1:0] num_reg  [DIV_W];
    logic [DIV_W-1:0] den_reg  [DIV_W];
    logic [DIV_W-1:0] quo_reg  [DIV_W];
    logic [DIV_W-1:0] rem_prev [DIV_W];
    logic [DIV_W-1:0] num_prev [DIV_W];
    logic [DIV_W-1:0] den_prev [DIV_W];
    logic [DIV_W-1:0] quo_prev [DIV_W];
    logic [DIV_W-1:0] rem_next [DIV_W];
    logic [DIV_W-1:0] num_next [DIV_W];
    logic [DIV_W-1:0] quo_next [DIV_W];
    logic [DIV_W:0]   trial    [DIV_W];
    logic [DIV_W:0]   diff     [DIV_W];
    logic [DIV_W-1:0] fits;

    assign valid_next = {valid_reg[DIV_W-2:0], in_valid};

    always_comb
    begin
        rem_prev[0] = '0;
        num_prev[0] = dividend;
        den_prev[0] = divisor;
        quo_prev[0] = '0;
        for (int s = 1; s < DIV_W; s++)
        begin
            rem_prev[s] = rem_reg[s-1];
            num_prev[s] = num_reg[s-1];
            den_prev[s] = den_reg[s-1];
            quo_prev[s] = quo_reg[s-1];
        end
        // The partial remainder stays below the divisor, so one extra bit holds the trial.
        for (int s = 0; s < DIV_W; s++)
        begin
            trial[s]    = {rem_prev[s], num_prev[s][DIV_W-1]};
            diff[s]     = trial[s] - {1'b0, den_prev[s]};
            fits[s]     = (trial[s] >= {1'b0, den_prev[s]});
            rem_next[s] = fits[s] ? diff[s][DIV_W-1:0] : trial[s][DIV_W-1:0];
            num_next[s] = {num_prev[s][DIV_W-2:0], 1'b0};
            quo_next[s] = {quo_prev[s][DIV_W-2:0], fits[s]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < DIV_W; s++)
        begin
            rem_reg[s] <= rem_next[s];
            num_reg[s] <= num_next[s];
            den_reg[s] <= den_prev[s];
            quo_reg[s] <= quo_next[s];
        end
    end

    assign out_valid = valid_reg[DIV_W-1];
    assign quotient  = quo_reg[DIV_W-1];

endmodule

>>> rtl/ntcb_ratio.sv
// ----------------------------------------------------------------------------
// NTC beta converter ratio front end
// Forms the clamped Q0.16 divider ratio and the two resistance products.
// ----------------------------------------------------------------------------
module ntcb_ratio
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic [ntcb_pkg::SAMPLE_W-1:0] sample,
    input  ntcb_pkg::cfg_t                cfg,
    output logic                          out_valid,
    output logic [ntcb_pkg::PROD_W-1:0]   num,
    output logic [ntcb_pkg::PROD_W-1:0]   den
);
    import ntcb_pkg::*;

    logic [RATIO_STAGES-1:0] valid_reg;
    logic [RATIO_STAGES-1:0] valid_next;
    logic [RATIO_STAGES-1:0] sat_reg;
    logic [RATIO_STAGES-1:0] sat_prev;
    logic [RATIO_W-1:0]      rem_reg  [RATIO_STAGES];
    logic [RATIO_W-1:0]      quo_reg  [RATIO_STAGES];
    logic [RATIO_W-1:0]      rem_prev [RATIO_STAGES];
    logic [RATIO_W-1:0]      quo_prev [RATIO_STAGES];
    logic [RATIO_W-1:0]      rem_next [RATIO_STAGES];
    logic [RATIO_W-1:0]      quo_next [RATIO_STAGES];
    logic [RATIO_W:0]        trial    [RATIO_STAGES];
    logic [RATIO_W:0]        diff     [RATIO_STAGES];
    logic [RATIO_STAGES-1:0] fits;

    logic                 clamp_valid_reg;
    logic [RATIO_W-1:0]   ratio_reg;
    logic [RATIO_W-1:0]   ratio_next;
    logic [RATIO_W-1:0]   quo_last;
    logic                 prod_valid_reg;
    logic [PROD_W-1:0]    num_reg;
    logic [PROD_W-1:0]    den_reg;
    logic [RATIO_W:0]     comp_ratio;

    assign valid_next = {valid_reg[RATIO_STAGES-2:0], in_valid};

    always_comb
    begin
        // A sample at or above full scale gives a ratio of one or more: clamp high.
        sat_prev[0] = (sample >= cfg.adc_full_scale);
        rem_prev[0] = sample;
        quo_prev[0] = '0;
        for (int s = 1; s < RATIO_STAGES; s++)
        begin
            sat_prev[s] = sat_reg[s-1];
            rem_prev[s] = rem_reg[s-1];
            quo_prev[s] = quo_reg[s-1];
        end
        for (int s = 0; s < RATIO_STAGES; s++)
        begin
            trial[s]    = {rem_prev[s], 1'b0};
            diff[s]     = trial[s] - {1'b0, cfg.adc_full_scale};
            fits[s]     = (trial[s] >= {1'b0, cfg.adc_full_scale});
            rem_next[s] = fits[s] ? diff[s][RATIO_W-1:0] : trial[s][RATIO_W-1:0];
            quo_next[s] = {quo_prev[s][RATIO_W-2:0], fits[s]};
        end
    end

    assign quo_last = quo_reg[RATIO_STAGES-1];

    always_comb
    begin
        if (sat_reg[RATIO_STAGES-1] || quo_last >= RATIO_HI)
        begin
            ratio_next = RATIO_HI;
        end
        else if (quo_last == '0)
        begin
            ratio_next = RATIO_LO;
        end
        else
        begin
            ratio_next = quo_last;
        end
    end

    assign comp_ratio = 17'h10000 - {1'b0, ratio_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            clamp_valid_reg <= 1'b0;
            prod_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg       <= valid_next;
            clamp_valid_reg <= valid_reg[RATIO_STAGES-1];
            prod_valid_reg  <= clamp_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < RATIO_STAGES; s++)
        begin
            sat_reg[s] <= sat_prev[s];
            rem_reg[s] <= rem_next[s];
            quo_reg[s] <= quo_next[s];
        end
        ratio_reg <= ratio_next;
        num_reg   <= PROD_W'(cfg.series_resistance * ratio_reg);
        den_reg   <= PROD_W'(comp_ratio * cfg.nominal_resistance);
    end

    assign out_valid = prod_valid_reg;
    assign num       = num_reg;
    assign den       = den_reg;

endmodule

>>> rtl/ntcb_log2.sv
// ----------------------------------------------------------------------------
// NTC beta converter base-two logarithm
// Q6.16 log2 by normalization and one mantissa squaring per stage.
// ----------------------------------------------------------------------------
module ntcb_log2
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic [ntcb_pkg::PROD_W-1:0] x,
    output logic                        out_valid,
    output logic [ntcb_pkg::LOG_W-1:0]  lg
);
    import ntcb_pkg::*;

    logic [LOG_INT_W-1:0] lead;
    logic [PROD_W-1:0]    shifted;
    logic                 norm_valid_reg;
    logic [LOG_INT_W-1:0] norm_int_reg;
    logic [MANT_W-1:0]    norm_mant_reg;

    logic [LOG_FRAC-1:0]  valid_reg;
    logic [LOG_FRAC-1:0]  valid_next;
    logic [LOG_INT_W-1:0] int_reg   [LOG_FRAC];
    logic [MANT_W-1:0]    mant_reg  [LOG_FRAC];
    logic [LOG_FRAC-1:0]  frac_reg  [LOG_FRAC];
    logic [LOG_INT_W-1:0] int_prev  [LOG_FRAC];
    logic [MANT_W-1:0]    mant_prev [LOG_FRAC];
    logic [LOG_FRAC-1:0]  frac_prev [LOG_FRAC];
    logic [MANT_W-1:0]    mant_next [LOG_FRAC];
    logic [LOG_FRAC-1:0]  frac_next [LOG_FRAC];
    logic [2*MANT_W-1:0]  square    [LOG_FRAC];

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < PROD_W; i++)
        begin
            if (x[i])
            begin
                lead = LOG_INT_W'(i);
            end
        end
        // Bring the top set bit to weight 2^30, giving a Q1.30 mantissa.
        if (lead >= LOG_INT_W'(MANT_W - 1))
        begin
            shifted = x >> (lead - LOG_INT_W'(MANT_W - 1));
        end
        else
        begin
            shifted = x << (LOG_INT_W'(MANT_W - 1) - lead);
        end
    end

    assign valid_next = {valid_reg[LOG_FRAC-2:0], norm_valid_reg};

    always_comb
    begin
        int_prev[0]  = norm_int_reg;
        mant_prev[0] = norm_mant_reg;
        frac_prev[0] = '0;
        for (int s = 1; s < LOG_FRAC; s++)
        begin
            int_prev[s]  = int_reg[s-1];
            mant_prev[s] = mant_reg[s-1];
            frac_prev[s] = frac_reg[s-1];
        end
        // Squaring doubles the log; a mantissa reaching 2.0 yields a fraction bit of one.
        for (int s = 0; s < LOG_FRAC; s++)
        begin
            square[s] = mant_prev[s] * mant_prev[s];
            if (square[s][2*MANT_W-1])
            begin
                mant_next[s] = square[s][2*MANT_W-1:MANT_W];
            end
            else
            begin
                mant_next[s] = square[s][2*MANT_W-2:MANT_W-1];
            end
            frac_next[s] = {frac_prev[s][LOG_FRAC-2:0], square[s][2*MANT_W-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            norm_valid_reg <= 1'b0;
            valid_reg      <= '0;
        end
        else
        begin
            norm_valid_reg <= in_valid;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        norm_int_reg  <= lead;
        norm_mant_reg <= shifted[MANT_W-1:0];
        for (int s = 0; s < LOG_FRAC; s++)
        begin
            int_reg[s]  <= int_prev[s];
            mant_reg[s] <= mant_next[s];
            frac_reg[s] <= frac_next[s];
        end
    end

    assign out_valid = valid_reg[LOG_FRAC-1];
    assign lg        = {int_reg[LOG_FRAC-1], frac_reg[LOG_FRAC-1]};

endmodule

>>> rtl/ntcb_checker.sv
// ----------------------------------------------------------------------------
// NTC beta converter checker
// Port-level checks on the converter's busy output and result beats, bound to the top level.
// ----------------------------------------------------------------------------
`include "ntc_beta_temperature_convert_defines.svh"

module ntcb_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               busy,
    input  logic                               done,
    input  logic signed [ntcb_pkg::TEMP_W-1:0] temperature_centi,
    input  logic [ntcb_pkg::STATUS_W-1:0]      status
);
    import ntcb_pkg::*;

    `NTCB_ASSERT_ALWAYS(a_never_busy, !busy, "converter refused a start beat")

    `NTCB_ASSERT_IMPLY(a_fs_zero_value, done && (status == STATUS_FS_ZERO), temperature_centi == '0, "zero full scale must give zero")

    `NTCB_ASSERT_IMPLY(a_ok_in_range, done && (status == STATUS_OK), (temperature_centi >= T_MIN_CENTI) && (temperature_centi <= T_MAX_CENTI), "unflagged result out of range")

    `NTCB_ASSERT_IMPLY(a_sat_at_rail, done && (status == STATUS_SATURATED), (temperature_centi == T_MAX_CENTI) || (temperature_centi == T_MIN_CENTI), "saturated result not at a rail")

endmodule

bind ntc_beta_temperature_convert ntcb_checker u_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .busy              (busy),
    .done              (done),
    .temperature_centi (temperature_centi),
    .status            (status)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// NTC beta converter testbench
// Drives ADC samples through the converter under several register settings
// and compares every temperature and status against a fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;
    import ntcb_pkg::*;

    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 130;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LAST  = 3'd7;

    typedef struct {
        logic signed [TEMP_W-1:0] temp;
        status_t                  st;
    } reading_t;

    class temp_scoreboard;
        logic [FS_W-1:0]          fs;
        logic [RES_W-1:0]         r_series;
        logic [RES_W-1:0]         r_nom;
        logic [BETA_W-1:0]        beta;
        logic signed [TNOM_W-1:0] t_nom;
        reading_t                 pending_q[$];
        int                       errors;

        function new();
            fs = 16'd4095;
            r_series = 23'd10000;
            r_nom = 23'd10000;
            beta = 16'd3950;
            t_nom = 16'sd2500;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                REG_ADC_FULL_SCALE: fs = d[FS_W-1:0];
                REG_SERIES_RES:     r_series = d;
                REG_NOMINAL_RES:    r_nom = d;
                REG_BETA:           beta = d[BETA_W-1:0];
                REG_NOMINAL_TEMP:   t_nom = d[TNOM_W-1:0];
                default: ;
            endcase
        endfunction

        // Q6.16 log2; the fraction comes from squaring a Q1.30 mantissa.
        function longint log2_fix(longint unsigned x);
            int n;
            longint unsigned y;
            longint frac;
            n = 63;
            frac = 0;
            while (n > 0 && x[n] == 1'b0)
                n--;
            y = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
            for (int i = 15; i >= 0; i--)
            begin
                y = (y * y) >> 30;
                if (y >= (64'd1 << 31))
                begin
                    y = y >> 1;
                    frac = frac | (longint'(1) << i);
                end
            end
            return longint'(n) * 65536 + frac;
        endfunction

        function longint div_round(longint a, longint unsigned b);
            longint unsigned mag;
            longint unsigned quo;
            mag = (a < 0) ? longint'(-a) : longint'(a);
            quo = (mag + b / 2) / b;
            return (a < 0) ? -longint'(quo) : longint'(quo);
        endfunction

        function reading_t convert(logic [SAMPLE_W-1:0] s);
            reading_t r;
            longint unsigned q, num, den, tq, hq, tku;
            longint tk, lg, lnv, inv;
            hq = 64'd100 << 32;
            tk = longint'(t_nom) + 27315;
            if (fs == 0)
            begin
                r.temp = '0;
                r.st = STATUS_FS_ZERO;
                return r;
            end
            if (r_series == 0 || r_nom == 0 || beta == 0 || tk <= 0)
            begin
                r.temp = T_MIN_CENTI;
                r.st = STATUS_SATURATED;
                return r;
            end
            q = ({48'd0, s} << 16) / {48'd0, fs};
            if (q == 0)
                q = 7;
            else if (q >= 65529)
                q = 65529;
            num = {41'd0, r_series} * q;
            den = (64'd65536 - q) * {41'd0, r_nom};
            lg = log2_fix(num) - log2_fix(den);
            lnv = div_round(lg * 64'sd2977044472, 64'd1 << 32);
            tku = tk;
            inv = div_round(lnv * 65536, {48'd0, beta}) + longint'((hq + tku / 2) / tku);
            if (inv <= 0)
            begin
                r.temp = (inv == 0) ? T_MAX_CENTI : T_MIN_CENTI;
                r.st = STATUS_SATURATED;
                return r;
            end
            tq = (hq + longint'(inv) / 2) / longint'(inv);
            if (tq > 127315)
            begin
                r.temp = T_MAX_CENTI;
                r.st = STATUS_SATURATED;
                return r;
            end
            r.temp = longint'(tq) - 27315;
            r.st = STATUS_OK;
            return r;
        endfunction

        function void note_sample(logic [SAMPLE_W-1:0] s);
            pending_q.push_back(convert(s));
        endfunction

        function void check_result(logic signed [TEMP_W-1:0] temp, logic [STATUS_W-1:0] st);
            reading_t e;
            if (pending_q.size() == 0)
            begin
                $error("unexpected result beat: temperature_centi %0d status %0d", temp, st);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (temp !== e.temp)
            begin
                $error("temperature_centi: expected %0d, actual %0d", e.temp, temp);
                errors++;
            end
            if (st !== e.st)
            begin
                $error("status: expected %0d, actual %0d", e.st, st);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [SAMPLE_W-1:0]    sample = '0;
    logic                   done;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic [STATUS_W-1:0]    status;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    temp_scoreboard sb = new();
    int  cycles = 0;
    bit  no_gaps = 1'b0;

    ntc_beta_temperature_convert u_top
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .sample            (sample),
        .done              (done),
        .temperature_centi (temperature_centi),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES)
        begin
            $display("ntc_beta_temperature_convert test failed");
            $finish;
        end
    end

    // Both beats are sampled here, before any of this edge's updates land.
    always @(posedge clk)
    begin
        if (rst_n && start && !busy)
            sb.note_sample(sample);
        if (rst_n && done)
            sb.check_result(temperature_centi, status);
    end

    task automatic send_sample(logic [SAMPLE_W-1:0] s);
        if (!no_gaps)
        begin
            while ($urandom_range(0, 99) < 32)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
        end
        start <= 1'b1;
        sample <= s;
        do @(posedge clk); while (busy);
    endtask

    // Sender pause: everything in flight comes back before registers change.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.pending_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(logic [FS_W-1:0] fs, logic [RES_W-1:0] rs,
                              logic [RES_W-1:0] rn, logic [BETA_W-1:0] b,
                              logic signed [TNOM_W-1:0] tn);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        idx = '{REG_ADC_FULL_SCALE, REG_SERIES_RES, REG_NOMINAL_RES, REG_BETA,
                REG_NOMINAL_TEMP};
        val = '{{7'd0, fs}, rs, rn, {7'd0, b}, {7'd0, tn}};
        for (int i = 0; i < 5; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_spare(logic [CFG_IDX_W-1:0] idx);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'($urandom());
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(int n);
        logic [FS_W-1:0] fs;
        logic [SAMPLE_W-1:0] s;
        fs = sb.fs;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 9) < 2 || fs == 0)
                s = SAMPLE_W'($urandom());
            else
                s = SAMPLE_W'($urandom_range(0, fs + fs / 8 > 65535 ? 65535 : fs + fs / 8));
            send_sample(s);
        end
        drain();
    endtask

    initial
    begin
        logic [FS_W-1:0] fs;
        logic [RES_W-1:0] rs, rn;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: rails, full scale, over range and alternating bits.
        send_sample(16'd0);
        send_sample(16'd1);
        send_sample(16'd2048);
        send_sample(16'd4094);
        send_sample(16'd4095);
        send_sample(16'd4096);
        send_sample(16'hAAAA);
        send_sample(16'h5555);
        send_sample(16'hFFFF);
        drain();

        // Indexes past the last register must leave the settings alone.
        write_spare(REG_SPARE);
        write_spare(REG_LAST);
        send_sample(16'd1000);
        drain();

        set_config(16'd0, 23'd10000, 23'd10000, 16'd3950, 16'sd2500);
        send_sample(16'd0);
        send_sample(16'd12345);
        drain();
        set_config(16'd4095, 23'd0, 23'd10000, 16'd3950, 16'sd2500);
        send_sample(16'd100);
        drain();
        set_config(16'd4095, 23'd10000, 23'd0, 16'd3950, 16'sd2500);
        send_sample(16'd100);
        drain();
        set_config(16'd4095, 23'd10000, 23'd10000, 16'd0, 16'sd2500);
        send_sample(16'd100);
        drain();
        set_config(16'd4095, 23'd10000, 23'd10000, 16'd3950, -16'sd27315);
        send_sample(16'd100);
        drain();
        set_config(16'd65535, 23'h7FFFFF, 23'd1, 16'd1, -16'sd32768);
        send_sample(16'd65535);
        drain();
        set_config(16'd65535, 23'd4194304, 23'd1, 16'd1, 16'sd32767);
        send_sample(16'd0);
        send_sample(16'd65535);
        drain();
        set_config(16'd1, 23'd1, 23'h7FFFFF, 16'd65535, -16'sd27314);
        send_sample(16'd0);
        send_sample(16'd1);
        drain();

        for (int p = 0; p < 12; p++)
        begin
            no_gaps = (p == 5);
            if (p % 4 == 3)
                set_config(FS_W'($urandom()), RES_W'($urandom()), RES_W'($urandom()),
                           BETA_W'($urandom()), TNOM_W'($urandom()));
            else
            begin
                fs = FS_W'($urandom_range(255, 65535));
                rs = RES_W'($urandom_range(1000, 100000));
                rn = RES_W'($urandom_range(1000, 100000));
                set_config(fs, rs, rn, BETA_W'($urandom_range(2000, 5000)),
                           TNOM_W'($urandom_range(0, 5000)));
            end
            random_phase(50);
        end
        no_gaps = 1'b0;
        set_config(16'd4095, 23'd10000, 23'd10000, 16'd3950, 16'sd2500);
        random_phase(40);

        if (sb.errors == 0 && sb.pending_q.size() == 0)
            $display("ntc_beta_temperature_convert test passed");
        else
            $display("ntc_beta_temperature_convert test failed");
        $finish;
    end

endmodule
